// File: sv/assert_macros.svh
// Assertion helpers for the thruster command decoder and mixer.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tcdm_pkg.sv
// Shared types, codes and constants of the thruster command decoder and mixer.
// No dependencies.
package tcdm_pkg;

  localparam int FRAME_BYTES_DEF = 5;

  localparam logic [7:0] MARKER    = 8'h9A;
  localparam logic [7:0] SPEED_MAX = 8'd100;

  // Direction letters.
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_Y = 8'h59;
  localparam logic [7:0] CH_A = 8'h41;

  typedef enum logic [1:0] {
    STATUS_NODATA = 2'd0,
    STATUS_DONE   = 2'd1,
    STATUS_ERROR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_POS,
    SEL_NEG,
    SEL_AUTO
  } motor_sel_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic signed [7:0] motor_0;
    logic signed [7:0] motor_1;
    logic signed [7:0] motor_2;
    logic signed [7:0] motor_3;
    logic signed [7:0] motor_4;
    logic signed [7:0] motor_5;
    logic [5:0]        updated_mask;
  } out_word_t;

  // Sequencer controls seen by the buffer, mixer and output register.
  typedef struct packed {
    logic    busy;
    logic    apply;
    logic    clear;
    logic    emit;
    status_t status;
  } ctl_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c == CH_F) || (c == CH_B) || (c == CH_R) || (c == CH_L) ||
           (c == CH_U) || (c == CH_D) || (c == CH_X) || (c == CH_Y);
  endfunction

endpackage

// File: sv/tcdm_scan.sv
// Frame scan sequencer: one buffered byte checked per cycle by one field checker.
// Depends on tcdm_pkg.
module tcdm_scan import tcdm_pkg::*; #(
  parameter int  FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int IDX_W       = $clog2(FRAME_BYTES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             out_free,
  input  logic [7:0]       scan_byte,
  input  logic [7:0]       first_byte,
  output logic [IDX_W-1:0] scan_idx,
  output ctl_t             ctl,
  output logic [7:0]       held_dir,
  output logic [7:0]       held_speed
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       dir_r, dir_nxt;
  logic [7:0]       speed_r, speed_nxt;
  status_t          status_r, status_nxt;

  logic    is_mark, is_auto, is_last, field_bad, step_end;
  status_t step_status;

  // Field checker shared by every position of the frame.
  always_comb begin
    is_mark   = (scan_byte == MARKER);
    is_auto   = (first_byte == CH_A);
    is_last   = (idx_r == IDX_LAST);
    field_bad = idx_r[0] ? (scan_byte > SPEED_MAX) : !is_letter(scan_byte);
    step_end  = is_mark || (!is_auto && field_bad) || is_last;
    if (is_mark) begin
      step_status = (idx_r == '0) ? STATUS_NODATA : STATUS_DONE;
    end else if (!is_auto && field_bad) begin
      step_status = STATUS_ERROR;
    end else begin
      step_status = STATUS_DONE;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (step_end) state_nxt = (step_status == STATUS_DONE) ? ST_APPLY : ST_EMIT;
      end
      ST_APPLY: state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates; held fields survive a frame that fails later on.
  always_comb begin
    idx_nxt    = idx_r;
    dir_nxt    = dir_r;
    speed_nxt  = speed_r;
    status_nxt = status_r;
    if (state_r == ST_IDLE && start) begin
      idx_nxt = '0;
    end else if (state_r == ST_SCAN) begin
      if (!step_end) idx_nxt = idx_r + 1'b1;
      if (step_end) status_nxt = step_status;
      if (!is_mark && !is_auto && !field_bad) begin
        if (idx_r[0]) speed_nxt = scan_byte;
        else          dir_nxt   = scan_byte;
      end
      if (!is_mark && is_auto && is_last) dir_nxt = CH_A;
    end
  end

  // Outputs.
  always_comb begin
    ctl.busy   = (state_r != ST_IDLE);
    ctl.apply  = (state_r == ST_APPLY);
    ctl.clear  = (state_r == ST_APPLY) ||
                 (state_r == ST_SCAN && step_end && step_status == STATUS_ERROR);
    ctl.emit   = (state_r == ST_EMIT) && out_free;
    ctl.status = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      dir_r    <= '0;
      speed_r  <= '0;
      status_r <= STATUS_NODATA;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      dir_r    <= dir_nxt;
      speed_r  <= speed_nxt;
      status_r <= status_nxt;
    end
  end

  assign scan_idx   = idx_r;
  assign held_dir   = dir_r;
  assign held_speed = speed_r;

endmodule

// File: sv/tcdm_mix.sv
// Motor mixer: sign rules per move and the six held motor commands.
// Depends on tcdm_pkg.
module tcdm_mix import tcdm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            apply,
  input  logic [7:0]      held_dir,
  input  logic [7:0]      held_speed,
  input  logic [3:0][7:0] auto_bytes,
  output logic [5:0][7:0] motor,
  output logic [5:0]      mask
);

  logic [5:0][7:0] motor_r, motor_nxt;
  logic [5:0]      mask_r, mask_nxt;
  motor_sel_t      sel [6];
  logic [7:0]      neg;
  logic [5:0][7:0] auto6;

  always_comb begin
    neg   = 8'd0 - held_speed;
    auto6 = {16'h0000, auto_bytes};
    for (int k = 0; k < 6; k++) sel[k] = SEL_HOLD;
    unique case (held_dir)
      CH_F: for (int k = 0; k < 4; k++) sel[k] = SEL_POS;
      CH_B: for (int k = 0; k < 4; k++) sel[k] = SEL_NEG;
      CH_U: begin sel[4] = SEL_POS; sel[5] = SEL_POS; end
      CH_D: begin sel[4] = SEL_NEG; sel[5] = SEL_NEG; end
      CH_R: begin
        sel[0] = SEL_POS; sel[1] = SEL_NEG; sel[2] = SEL_NEG; sel[3] = SEL_POS;
      end
      CH_L: begin
        sel[0] = SEL_NEG; sel[1] = SEL_POS; sel[2] = SEL_POS; sel[3] = SEL_NEG;
      end
      CH_X: begin
        sel[0] = SEL_POS; sel[1] = SEL_NEG; sel[2] = SEL_POS; sel[3] = SEL_NEG;
      end
      CH_Y: begin
        sel[0] = SEL_NEG; sel[1] = SEL_POS; sel[2] = SEL_NEG; sel[3] = SEL_POS;
      end
      CH_A: for (int k = 0; k < 4; k++) sel[k] = SEL_AUTO;
      default: ;
    endcase
  end

  always_comb begin
    motor_nxt = motor_r;
    mask_nxt  = mask_r;
    if (apply) begin
      for (int k = 0; k < 6; k++) begin
        mask_nxt[k] = (sel[k] != SEL_HOLD);
        case (sel[k])
          SEL_POS:  motor_nxt[k] = held_speed;
          SEL_NEG:  motor_nxt[k] = neg;
          SEL_AUTO: motor_nxt[k] = auto6[k];
          default:  motor_nxt[k] = motor_r[k];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_r <= '0;
      mask_r  <= '0;
    end else begin
      motor_r <= motor_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign motor = motor_r;
  assign mask  = mask_r;

endmodule

// File: sv/thruster_command_decoder_mixer.sv
// Thruster command decoder and mixer. Data words (operation 0) fill a frame buffer of
// FRAME_BYTES bytes, preset to the 0x9A marker; extra bytes are dropped. Each data word is
// taken while in_stall is low and yields no result. An end-of-frame word (operation 1)
// starts a scan: one field checker walks the buffer one byte per cycle up to the first
// marker, a bad field or the last byte, checking direction letters at even positions and
// speeds 0..100 at odd positions and updating the held direction and speed as it goes; an
// auto frame (first byte 0x41) skips the checks. An accepted frame then passes the apply
// state, where the mixer rewrites the motors selected by the held move, and the emit
// state, which loads the result register. The input stalls through the scan, apply and
// emit states; a previous result held by out_stall delays the load. Exactly one
// result word follows each end-of-frame word: status no-data, done or error, the six held
// motor commands and a mask of the motors this frame wrote (zero unless done). Done and
// error refill the buffer with the marker; an empty frame leaves it as it is. The result
// register lets new data words in while a result waits on out_stall.
// Depends on tcdm_pkg, tcdm_scan, tcdm_mix and assert_macros.svh.
`include "assert_macros.svh"

module thruster_command_decoder_mixer import tcdm_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [7:0]       buf_r [FRAME_BYTES];
  logic [CNT_W-1:0] count_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic             in_fire, eof_fire, data_fire, out_free;
  ctl_t             ctl;
  logic [IDX_W-1:0] scan_idx;
  logic [7:0]       held_dir, held_speed;
  logic [3:0][7:0]  auto_bytes;
  logic [5:0][7:0]  motor;
  logic [5:0]       mask;

  assign in_stall  = ctl.busy;
  assign in_fire   = in_valid && !in_stall;
  assign eof_fire  = in_fire && in_data.operation;
  assign data_fire = in_fire && !in_data.operation;
  assign out_free  = !out_valid_r || !out_stall;

  // Auto frames read bytes 1..4; positions past the buffer read as the marker.
  for (genvar k = 0; k < 4; k++) begin : g_auto
    if (k + 1 < FRAME_BYTES) begin : g_in
      assign auto_bytes[k] = buf_r[k+1];
    end else begin : g_past
      assign auto_bytes[k] = MARKER;
    end
  end

  tcdm_scan #(.FRAME_BYTES(FRAME_BYTES)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (eof_fire),
    .out_free   (out_free),
    .scan_byte  (buf_r[scan_idx]),
    .first_byte (buf_r[0]),
    .scan_idx   (scan_idx),
    .ctl        (ctl),
    .held_dir   (held_dir),
    .held_speed (held_speed)
  );

  tcdm_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .apply      (ctl.apply),
    .held_dir   (held_dir),
    .held_speed (held_speed),
    .auto_bytes (auto_bytes),
    .motor      (motor),
    .mask       (mask)
  );

  // Frame buffer and fill count: clear to the marker on done or error, append otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) buf_r[i] <= MARKER;
    end else begin
      if (ctl.clear) begin
        for (int i = 0; i < FRAME_BYTES; i++) buf_r[i] <= MARKER;
      end else if (data_fire && count_r < CNT_W'(FRAME_BYTES)) begin
        buf_r[count_r[IDX_W-1:0]] <= in_data.data_byte;
      end
      if (eof_fire) begin
        count_r <= '0;
      end else if (data_fire && count_r < CNT_W'(FRAME_BYTES)) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Result register: load on emit, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data_r.status       <= ctl.status;
      out_data_r.motor_0      <= $signed(motor[0]);
      out_data_r.motor_1      <= $signed(motor[1]);
      out_data_r.motor_2      <= $signed(motor[2]);
      out_data_r.motor_3      <= $signed(motor[3]);
      out_data_r.motor_4      <= $signed(motor[4]);
      out_data_r.motor_5      <= $signed(motor[5]);
      out_data_r.updated_mask <= (ctl.status == STATUS_DONE) ? mask : 6'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_mask_only_on_done,
    out_valid && out_data.status != STATUS_DONE, out_data.updated_mask == 6'd0,
    "motor mask set on a frame that was not accepted")
  `ASSERT_HOLDS(a_count_bound, count_r <= CNT_W'(FRAME_BYTES),
    "fill count ran past the frame buffer")
  `ASSERT_NEXT(a_eof_blocks_input, in_valid && !in_stall && in_data.operation, in_stall,
    "input not held during frame scan")

endmodule
